@@ rtl/gbsa_pkg.sv @@
package gbsa_pkg;

    // field widths
    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    localparam int SUM_W = 64;
    localparam int ACT_W = 11;

    // table size default
    localparam int MAX_GROUPS_DEF = 1024;

    // configuration
    localparam logic [ACT_W-1:0] ACTIVE_RESET = 11'd1024;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register index, taken from paddr[2]
    localparam logic REG_ACTIVE_GROUPS = 1'b0;

    // operation codes
    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_READ = 1'b1
    } t_op;

endpackage

@@ rtl/gbsa_table.sv @@
module gbsa_table #(
    parameter int MAX_GROUPS = gbsa_pkg::MAX_GROUPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(MAX_GROUPS)-1:0] i_rd_addr,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAX_GROUPS)-1:0] i_wr_addr,
    input  logic [gbsa_pkg::SUM_W-1:0]    i_wr_data,
    output logic [gbsa_pkg::SUM_W-1:0]    o_rd_data,
    output logic                          o_busy
);

    localparam int AW = $clog2(MAX_GROUPS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_GROUPS - 1);

    logic [gbsa_pkg::SUM_W-1:0] mem [MAX_GROUPS];
    logic [gbsa_pkg::SUM_W-1:0] r_mem_q;
    logic [AW-1:0]              r_rd_addr;

    logic                       r_busy;
    logic [AW-1:0]              r_clr_addr;

    logic                       r_fwd_valid;
    logic [AW-1:0]              r_fwd_addr;
    logic [gbsa_pkg::SUM_W-1:0] r_fwd_data;

    logic                       mem_we;
    logic [AW-1:0]              mem_wa;
    logic [gbsa_pkg::SUM_W-1:0] mem_wd;

    // clearing pass owns the write port after reset
    always_comb begin
        mem_we = r_busy || i_wr_en;
        mem_wa = r_busy ? r_clr_addr : i_wr_addr;
        mem_wd = r_busy ? '0 : i_wr_data;
    end

    // single port pair memory, read-first, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_mem_q   <= mem[i_rd_addr];
        r_rd_addr <= i_rd_addr;
    end

    // clear sweep, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_ADDR) begin
                r_busy <= 1'b0;
            end
        end
    end

    // last write kept to cover a read issued on the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (i_wr_en && !r_busy) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && !r_busy) begin
            r_fwd_addr <= i_wr_addr;
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = (r_fwd_valid && r_fwd_addr == r_rd_addr) ? r_fwd_data : r_mem_q;
    assign o_busy    = r_busy;

endmodule

@@ rtl/group_by_sum_accumulator_core.sv @@
// Group-by sum engine: a table of signed 64-bit sums, one per group.
// Input channel (i_in_valid / o_in_ready) carries one word: i_op, i_group_index,
// i_value. An add word adds the sign-extended value to its group and gives no
// result. A read word returns the group's sum on the output channel
// (o_out_valid / i_out_ready) and clears the entry. Indices at or above the
// active group count (APB register 0, reset 1024, capped at MAX_GROUPS) are
// rejected: adds are dropped, reads return a zero sum with o_index_error set.
// Throughput is one word per cycle while o_in_ready is high; the table memory
// is read on acceptance and written back from the modify stage, with the last
// write forwarded so the same group may repeat on back-to-back words. A read
// result passes through the modify stage into the output register.
// When the receiver stalls with a result held, a following read word waits in
// the modify stage and o_in_ready drops; add words keep flowing.
// After reset the table is zeroed by a sweep over all MAX_GROUPS entries (1024 by
// default) during which o_in_ready stays low; APB writes are taken as usual.
module group_by_sum_accumulator_core #(
    parameter int MAX_GROUPS = gbsa_pkg::MAX_GROUPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  logic [gbsa_pkg::IDX_W-1:0]    i_group_index,
    input  logic signed [gbsa_pkg::VAL_W-1:0] i_value,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [gbsa_pkg::IDX_W-1:0]    o_result_group,
    output logic signed [gbsa_pkg::SUM_W-1:0] o_group_sum,
    output logic                          o_index_error,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gbsa_pkg::APB_AW-1:0]   paddr,
    input  logic [gbsa_pkg::APB_DW-1:0]   pwdata,
    output logic [gbsa_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int AW = $clog2(MAX_GROUPS);
    localparam int IW = (AW > gbsa_pkg::IDX_W) ? AW : gbsa_pkg::IDX_W;

    logic [gbsa_pkg::ACT_W-1:0] r_active;

    logic                       r_s1_valid;
    logic                       n_s1_valid;
    gbsa_pkg::t_op              r_s1_op;
    logic [gbsa_pkg::IDX_W-1:0] r_s1_idx;
    logic                       r_s1_ok;
    logic [gbsa_pkg::VAL_W-1:0] r_s1_value;

    logic                       r_out_valid;
    logic                       n_out_valid;
    logic [gbsa_pkg::IDX_W-1:0] r_out_group;
    logic [gbsa_pkg::SUM_W-1:0] r_out_sum;
    logic                       r_out_err;

    logic                       in_fire;
    logic                       in_ok;
    logic                       s1_go;
    logic                       out_load;
    logic                       cfg_wr;
    logic [IW-1:0]              in_idx_w;
    logic [IW-1:0]              s1_idx_w;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              s1_addr;
    logic                       tbl_wr_en;
    logic [gbsa_pkg::SUM_W-1:0] tbl_wr_data;
    logic [gbsa_pkg::SUM_W-1:0] tbl_rd_data;
    logic                       tbl_busy;
    logic [gbsa_pkg::SUM_W-1:0] sum_add;

    // configuration register
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = gbsa_pkg::APB_DW'(r_active);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= gbsa_pkg::ACTIVE_RESET;
        end else if (cfg_wr && paddr[2] == gbsa_pkg::REG_ACTIVE_GROUPS) begin
            r_active <= pwdata[gbsa_pkg::ACT_W-1:0];
        end
    end

    // handshake and stage control
    assign s1_go      = !(r_s1_op == gbsa_pkg::OP_READ && r_out_valid && !i_out_ready);
    assign o_in_ready = !tbl_busy && (!r_s1_valid || s1_go);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_load   = r_s1_valid && s1_go && r_s1_op == gbsa_pkg::OP_READ;

    // range check against the capped group count
    assign in_ok = (32'(i_group_index) < 32'(r_active)) &&
                   (32'(i_group_index) < 32'(MAX_GROUPS));

    // table addresses
    assign in_idx_w = IW'(i_group_index);
    assign s1_idx_w = IW'(r_s1_idx);
    assign s1_addr  = s1_idx_w[AW-1:0];
    assign rd_addr  = in_fire ? in_idx_w[AW-1:0] : s1_addr;

    // modify stage
    assign sum_add     = tbl_rd_data +
                         {{(gbsa_pkg::SUM_W - gbsa_pkg::VAL_W){r_s1_value[gbsa_pkg::VAL_W-1]}},
                          r_s1_value};
    assign tbl_wr_en   = r_s1_valid && s1_go && r_s1_ok;
    assign tbl_wr_data = (r_s1_op == gbsa_pkg::OP_ADD) ? sum_add : '0;

    gbsa_table #(
        .MAX_GROUPS (MAX_GROUPS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (s1_addr),
        .i_wr_data (tbl_wr_data),
        .o_rd_data (tbl_rd_data),
        .o_busy    (tbl_busy)
    );

    // stage valid flags
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_fire) begin
            n_s1_valid = 1'b1;
        end else if (s1_go) begin
            n_s1_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1_op     <= gbsa_pkg::OP_ADD;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (in_fire) begin
                r_s1_op <= gbsa_pkg::t_op'(i_op);
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_idx   <= i_group_index;
            r_s1_ok    <= in_ok;
            r_s1_value <= i_value;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_group <= r_s1_idx;
            r_out_sum   <= r_s1_ok ? tbl_rd_data : '0;
            r_out_err   <= !r_s1_ok;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_group = r_out_group;
    assign o_group_sum    = r_out_sum;
    assign o_index_error  = r_out_err;

endmodule

@@ rtl/gbsa_checker.sv @@
module gbsa_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              i_op,
    input logic [gbsa_pkg::IDX_W-1:0]        i_group_index,
    input logic signed [gbsa_pkg::VAL_W-1:0] i_value,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [gbsa_pkg::IDX_W-1:0]        o_result_group,
    input logic signed [gbsa_pkg::SUM_W-1:0] o_group_sum,
    input logic                              o_index_error,
    input logic                              psel,
    input logic                              penable,
    input logic                              pready
);

    // a waiting input word holds with its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_op) &&
        $stable(i_group_index) && $stable(i_value))
        else $error("input word changed while waiting");

    // a stalled result word holds with its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_group_sum) &&
        $stable(o_result_group) && $stable(o_index_error))
        else $error("result word changed while stalled");

    // a rejected read carries a zero sum
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_index_error |-> o_group_sum == '0)
        else $error("rejected read with nonzero sum");

    // the clearing sweep starts at reset: nothing taken, nothing shown
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("block active right after reset");

    // an apb write completes in its access cycle
    a_apb_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable |-> pready)
        else $error("apb access not completed");

endmodule

bind group_by_sum_accumulator_core gbsa_checker u_gbsa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_op           (i_op),
    .i_group_index  (i_group_index),
    .i_value        (i_value),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_result_group (o_result_group),
    .o_group_sum    (o_group_sum),
    .o_index_error  (o_index_error),
    .psel           (psel),
    .penable        (penable),
    .pready         (pready)
);
